// ===== design/osr_pkg.sv =====
// Shared types, constants and fixed-point helpers for the outline shape rasterizer.
`default_nettype none

package osr_pkg;

  localparam int unsigned IMAGE_SIZE  = 256;
  localparam int unsigned ANGLE_STEPS = 629;

  localparam int unsigned POS_W   = 10;
  localparam int unsigned EXT_W   = 10;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned ROT_W   = 32;
  localparam int unsigned MUL_W   = 64;
  localparam int unsigned C16_W   = 19;
  localparam int unsigned PROD_W  = 30;

  // rotation by 0.01 rad, Q1.30
  localparam logic signed [ROT_W-1:0] COS_STEP = 32'sd1073688137;
  localparam logic signed [ROT_W-1:0] SIN_STEP = 32'sd10737239;
  localparam logic signed [ROT_W-1:0] ONE_Q30  = 32'sd1073741824;

  typedef enum logic [1:0] {
    REQ_RECT,
    REQ_OVAL,
    REQ_READ
  } req_e;

  typedef enum logic [1:0] {
    ST_DRAWN,
    ST_REJECT,
    ST_READ
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RECT_H,
    S_RECT_V,
    S_OVAL_MUL,
    S_OVAL_RND,
    S_OVAL_LAST,
    S_READ,
    S_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic rect_h;
    logic rect_v;
    logic cnt_clr;
    logic oval_mul;
    logic oval_rnd;
    logic oval_plot;
    logic rd;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pos_ok;
    logic rd_ok;
    logic i_eq_w;
    logic i_eq_h;
    logic k_last;
    logic rd_pix;
  } stat_t;

  // Q1.30 product sum down to Q1.30, half away from zero
  function automatic logic signed [ROT_W-1:0] round_q30(input logic signed [MUL_W-1:0] v);
    logic [MUL_W-1:0] mag;
    logic [MUL_W-1:0] q;
    mag = v[MUL_W-1] ? MUL_W'(-v) : MUL_W'(v);
    q   = (mag + (MUL_W'(1) << 29)) >> 30;
    return v[MUL_W-1] ? ROT_W'(-q) : ROT_W'(q);
  endfunction

  // Q1.30 to Q1.16, half away from zero
  function automatic logic signed [C16_W-1:0] round_q14(input logic signed [ROT_W-1:0] v);
    logic [ROT_W-1:0] mag;
    logic [ROT_W-1:0] q;
    mag = v[ROT_W-1] ? ROT_W'(-v) : ROT_W'(v);
    q   = (mag + (ROT_W'(1) << 13)) >> 14;
    return v[ROT_W-1] ? C16_W'(-q) : C16_W'(q);
  endfunction

  // extent * Q1.16 / 2^17, toward zero
  function automatic logic signed [COORD_W-1:0] trunc_q17(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] q;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    q   = mag >> 17;
    return p[PROD_W-1] ? COORD_W'(-q) : COORD_W'(q);
  endfunction

endpackage

`default_nettype wire

// ===== design/osr_rotator.sv =====
// Fixed-point sine/cosine rotator producing Q1.16 samples at 0.01 rad steps.
`default_nettype none

module osr_rotator (
  input  wire logic                                clk_i,
  input  wire logic                                init_i,
  input  wire logic                                mul_i,
  input  wire logic                                rnd_i,
  output logic signed [osr_pkg::C16_W-1:0]         c16_o,
  output logic signed [osr_pkg::C16_W-1:0]         s16_o
);

  localparam int unsigned MW = osr_pkg::MUL_W;

  logic signed [osr_pkg::ROT_W-1:0] cx_q, cx_d, sy_q, sy_d;
  logic signed [osr_pkg::MUL_W-1:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [osr_pkg::MUL_W-1:0] p1_d, p2_d, p3_d, p4_d;
  logic signed [osr_pkg::C16_W-1:0] c16_q, s16_q;

  always_comb begin
    p1_d = MW'(cx_q) * MW'(osr_pkg::COS_STEP);
    p2_d = MW'(sy_q) * MW'(osr_pkg::SIN_STEP);
    p3_d = MW'(sy_q) * MW'(osr_pkg::COS_STEP);
    p4_d = MW'(cx_q) * MW'(osr_pkg::SIN_STEP);
    cx_d = osr_pkg::round_q30(p1_q - p2_q);
    sy_d = osr_pkg::round_q30(p3_q + p4_q);
  end

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      cx_q <= osr_pkg::ONE_Q30;
      sy_q <= '0;
    end else if (rnd_i) begin
      cx_q <= cx_d;
      sy_q <= sy_d;
    end
    if (mul_i) begin
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      p3_q  <= p3_d;
      p4_q  <= p4_d;
      c16_q <= osr_pkg::round_q14(cx_q);
      s16_q <= osr_pkg::round_q14(sy_q);
    end
  end

  assign c16_o = c16_q;
  assign s16_o = s16_q;

endmodule

`default_nettype wire

// ===== design/osr_datapath.sv =====
// Datapath: request registers, edge counters, ellipse offsets and the frame memory.
`default_nettype none

module osr_datapath #(
  parameter int unsigned IMAGE_SIZE  = osr_pkg::IMAGE_SIZE,
  parameter int unsigned ANGLE_STEPS = osr_pkg::ANGLE_STEPS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic signed [osr_pkg::POS_W-1:0]    pos_row_i,
  input  wire logic signed [osr_pkg::POS_W-1:0]    pos_col_i,
  input  wire logic [osr_pkg::EXT_W-1:0]           extent_rows_i,
  input  wire logic [osr_pkg::EXT_W-1:0]           extent_cols_i,
  input  wire osr_pkg::cmd_t                       cmd_i,
  output osr_pkg::stat_t                           stat_o
);

  localparam int unsigned AW    = $clog2(IMAGE_SIZE);
  localparam int unsigned DEPTH = 2 ** (2 * AW);
  localparam int unsigned KW    = (ANGLE_STEPS > 1) ? $clog2(ANGLE_STEPS) : 1;
  localparam int unsigned CW    = osr_pkg::COORD_W;
  localparam int unsigned PW    = osr_pkg::PROD_W;
  localparam int unsigned PADW  = osr_pkg::COORD_W - osr_pkg::EXT_W;
  localparam logic signed [CW-1:0] IMG_S  = CW'(IMAGE_SIZE);
  localparam logic [KW-1:0]        K_LAST = KW'(ANGLE_STEPS - 1);

  logic signed [CW-1:0]               r_q, c_q;
  logic [osr_pkg::EXT_W-1:0]          h_q, w_q, i_q;
  logic                               sub_q, pend_q;
  logic [KW-1:0]                      k_q;
  logic [2*AW-1:0]                    clr_addr_q;
  logic signed [osr_pkg::PROD_W-1:0]  pr_q, pc_q;
  logic                               rd_pix_q;
  logic                               frame_mem [DEPTH];

  logic signed [osr_pkg::C16_W-1:0]   c16, s16;
  logic signed [CW-1:0]               row_in, col_in, h_ext, w_ext, i_ext;
  logic signed [CW-1:0]               plot_row, plot_col;
  logic                               plot_req, plot_in;
  logic                               wr_en, wr_bit;
  logic [2*AW-1:0]                    wr_addr, rd_addr;

  osr_rotator u_rot (
    .clk_i  (clk_i),
    .init_i (cmd_i.load),
    .mul_i  (cmd_i.oval_mul),
    .rnd_i  (cmd_i.oval_rnd),
    .c16_o  (c16),
    .s16_o  (s16)
  );

  always_comb begin
    row_in = CW'(pos_row_i);
    col_in = CW'(pos_col_i);
    h_ext  = $signed({{PADW{1'b0}}, h_q});
    w_ext  = $signed({{PADW{1'b0}}, w_q});
    i_ext  = $signed({{PADW{1'b0}}, i_q});

    if (cmd_i.rect_h) begin
      plot_row = sub_q ? r_q + h_ext : r_q;
      plot_col = c_q + i_ext;
    end else if (cmd_i.rect_v) begin
      plot_row = r_q + i_ext;
      plot_col = sub_q ? c_q + w_ext : c_q;
    end else begin
      plot_row = r_q + osr_pkg::trunc_q17(pr_q);
      plot_col = c_q + osr_pkg::trunc_q17(pc_q);
    end
    plot_req = cmd_i.rect_h | cmd_i.rect_v | (cmd_i.oval_plot & pend_q);
    plot_in  = !plot_row[CW-1] && (plot_row < IMG_S) &&
               !plot_col[CW-1] && (plot_col < IMG_S);

    wr_en   = cmd_i.clear | (plot_req & plot_in);
    wr_bit  = !cmd_i.clear;
    wr_addr = cmd_i.clear ? clr_addr_q : {plot_row[AW-1:0], plot_col[AW-1:0]};
    rd_addr = {r_q[AW-1:0], c_q[AW-1:0]};

    stat_o.clr_last = &clr_addr_q;
    stat_o.pos_ok   = (row_in <= IMG_S) && (col_in <= IMG_S);
    stat_o.rd_ok    = !row_in[CW-1] && (row_in < IMG_S) &&
                      !col_in[CW-1] && (col_in < IMG_S);
    stat_o.i_eq_w   = (i_q == w_q);
    stat_o.i_eq_h   = (i_q == h_q);
    stat_o.k_last   = (k_q == K_LAST);
    stat_o.rd_pix   = rd_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      i_q        <= '0;
      sub_q      <= 1'b0;
      pend_q     <= 1'b0;
      k_q        <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (cmd_i.load || cmd_i.cnt_clr) begin
        i_q   <= '0;
        sub_q <= 1'b0;
      end else if (cmd_i.rect_h || cmd_i.rect_v) begin
        sub_q <= !sub_q;
        if (sub_q) begin
          i_q <= i_q + 1'b1;
        end
      end
      if (cmd_i.load) begin
        pend_q <= 1'b0;
        k_q    <= '0;
      end else if (cmd_i.oval_rnd) begin
        pend_q <= 1'b1;
        k_q    <= k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q <= row_in;
      c_q <= col_in;
      h_q <= extent_rows_i;
      w_q <= extent_cols_i;
    end
    if (cmd_i.oval_rnd) begin
      pr_q <= PW'($signed({1'b0, h_q})) * PW'(c16);
      pc_q <= PW'($signed({1'b0, w_q})) * PW'(s16);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_bit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_pix_q <= frame_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/osr_ctrl.sv =====
// Controller: request sequencing state machine and result strobe.
`default_nettype none

module osr_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  input  wire logic [1:0]                 req_type_i,
  input  wire osr_pkg::stat_t             stat_i,
  output osr_pkg::cmd_t                   cmd_o,
  output logic                            busy,
  output logic                            done_o,
  output logic [1:0]                      cmd_status_o,
  output logic                            pixel_black_o
);

  osr_pkg::state_e  state_q, state_d;
  osr_pkg::status_e status_q, status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= osr_pkg::S_CLEAR;
      status_q <= osr_pkg::ST_DRAWN;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    case (state_q)
      osr_pkg::S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clr_last) begin
          state_d = osr_pkg::S_IDLE;
        end
      end
      osr_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          status_d   = osr_pkg::ST_REJECT;
          state_d    = osr_pkg::S_RESP;
          case (osr_pkg::req_e'(req_type_i))
            osr_pkg::REQ_RECT: begin
              if (stat_i.pos_ok) begin
                status_d = osr_pkg::ST_DRAWN;
                state_d  = osr_pkg::S_RECT_H;
              end
            end
            osr_pkg::REQ_OVAL: begin
              if (stat_i.pos_ok) begin
                status_d = osr_pkg::ST_DRAWN;
                state_d  = osr_pkg::S_OVAL_MUL;
              end
            end
            osr_pkg::REQ_READ: begin
              if (stat_i.pos_ok && stat_i.rd_ok) begin
                status_d = osr_pkg::ST_READ;
                state_d  = osr_pkg::S_READ;
              end
            end
            default: begin
              status_d = osr_pkg::ST_REJECT;
            end
          endcase
        end
      end
      osr_pkg::S_RECT_H: begin
        if (stat_i.i_eq_w) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = osr_pkg::S_RECT_V;
        end else begin
          cmd_o.rect_h = 1'b1;
        end
      end
      osr_pkg::S_RECT_V: begin
        if (stat_i.i_eq_h) begin
          state_d = osr_pkg::S_RESP;
        end else begin
          cmd_o.rect_v = 1'b1;
        end
      end
      osr_pkg::S_OVAL_MUL: begin
        cmd_o.oval_mul  = 1'b1;
        cmd_o.oval_plot = 1'b1;
        state_d         = osr_pkg::S_OVAL_RND;
      end
      osr_pkg::S_OVAL_RND: begin
        cmd_o.oval_rnd = 1'b1;
        state_d = stat_i.k_last ? osr_pkg::S_OVAL_LAST : osr_pkg::S_OVAL_MUL;
      end
      osr_pkg::S_OVAL_LAST: begin
        cmd_o.oval_plot = 1'b1;
        state_d         = osr_pkg::S_RESP;
      end
      osr_pkg::S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = osr_pkg::S_RESP;
      end
      osr_pkg::S_RESP: begin
        state_d = osr_pkg::S_IDLE;
      end
      default: begin
        state_d = osr_pkg::S_IDLE;
      end
    endcase
  end

  assign busy          = (state_q != osr_pkg::S_IDLE);
  assign done_o        = (state_q == osr_pkg::S_RESP);
  assign cmd_status_o  = done_o ? status_q : 2'b00;
  assign pixel_black_o = done_o && (status_q == osr_pkg::ST_READ) && stat_i.rd_pix;

endmodule

`default_nettype wire

// ===== design/outline_shape_rasterizer.sv =====
// Top level: one-bit frame buffer that draws rectangle and ellipse outlines and reads pixels.
//
// After reset the block holds busy high while it clears the frame, one pixel
// per cycle, over all 2^(2*ceil(log2(IMAGE_SIZE))) locations (65536 at the
// default size). A request is taken when start is high and busy is low; its
// single result appears for one cycle with done_o and must be captured then,
// as the block cannot be held off. Rectangles are limited by the single frame
// write port, one pixel per cycle; ellipses by the multiply and round states
// of the sine/cosine rotator loop. busy stays high until the result has been
// shown.
`default_nettype none

module outline_shape_rasterizer #(
  parameter int unsigned IMAGE_SIZE  = osr_pkg::IMAGE_SIZE,
  parameter int unsigned ANGLE_STEPS = osr_pkg::ANGLE_STEPS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        req_type_i,
  input  wire logic signed [osr_pkg::POS_W-1:0]  pos_row_i,
  input  wire logic signed [osr_pkg::POS_W-1:0]  pos_col_i,
  input  wire logic [osr_pkg::EXT_W-1:0]         extent_rows_i,
  input  wire logic [osr_pkg::EXT_W-1:0]         extent_cols_i,
  output logic                                   done_o,
  output logic [1:0]                             cmd_status_o,
  output logic                                   pixel_black_o
);

  osr_pkg::cmd_t  cmd;
  osr_pkg::stat_t stat;

  osr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .req_type_i    (req_type_i),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .busy          (busy),
    .done_o        (done_o),
    .cmd_status_o  (cmd_status_o),
    .pixel_black_o (pixel_black_o)
  );

  osr_datapath #(
    .IMAGE_SIZE  (IMAGE_SIZE),
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pos_row_i     (pos_row_i),
    .pos_col_i     (pos_col_i),
    .extent_rows_i (extent_rows_i),
    .extent_cols_i (extent_cols_i),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

`default_nettype wire

// ===== design/osr_check.sv =====
// Port-level assertion checker for the outline shape rasterizer, with its bind.
`default_nettype none

module osr_check (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done_o,
  input wire logic [1:0] cmd_status_o,
  input wire logic       pixel_black_o
);

  // an accepted request always holds off the next one
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  // exactly one result cycle per request
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result shown while idle");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cmd_status_o == osr_pkg::ST_DRAWN || cmd_status_o == osr_pkg::ST_REJECT ||
                cmd_status_o == osr_pkg::ST_READ))
    else $error("illegal status code");

  a_pixel_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_black_o |-> done_o && cmd_status_o == osr_pkg::ST_READ)
    else $error("pixel set outside a read result");

endmodule

bind outline_shape_rasterizer osr_check u_osr_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .cmd_status_o  (cmd_status_o),
  .pixel_black_o (pixel_black_o)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the outline shape rasterizer: draws, reads and rejects.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import osr_pkg::*;

  localparam int IMG = int'(osr_pkg::IMAGE_SIZE);
  localparam int STEPS = int'(osr_pkg::ANGLE_STEPS);
  localparam logic [1:0] REQ_UNUSED = 2'b11;
  localparam int LIMIT_CYCLES = 20_000_000;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int HIT_SLOTS = 64;

  typedef struct {
    status_e status;
    logic    black;
  } reply_t;

  typedef struct {
    logic [1:0] kind;
    int         row;
    int         col;
    int         rows;
    int         cols;
    bit         typed;
    status_e    status;
    logic       black;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type_i = REQ_READ;
  logic signed [POS_W-1:0] pos_row_i = '0;
  logic signed [POS_W-1:0] pos_col_i = '0;
  logic [EXT_W-1:0] extent_rows_i = '0;
  logic [EXT_W-1:0] extent_cols_i = '0;
  logic done_o;
  logic [1:0] cmd_status_o;
  logic pixel_black_o;

  bit frame_bits [0:IMG*IMG-1];
  int hit_row [HIT_SLOTS];
  int hit_col [HIT_SLOTS];
  int hit_wr = 0;
  int hit_cnt = 0;

  reply_t pending_replies [$];
  plan_row_t plan [$];
  reply_t want;

  int errors = 0;
  int replies_seen = 0;
  int cycles = 0;
  int n_rect = 0;
  int n_oval = 0;
  int n_read = 0;
  int n_black = 0;
  int n_reject = 0;
  int idle_pct [3] = '{17, 64, 0};

  outline_shape_rasterizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .pos_row_i     (pos_row_i),
    .pos_col_i     (pos_col_i),
    .extent_rows_i (extent_rows_i),
    .extent_cols_i (extent_cols_i),
    .done_o        (done_o),
    .cmd_status_o  (cmd_status_o),
    .pixel_black_o (pixel_black_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TIMEOUT after %0d cycles, %0d replies outstanding", cycles,
               pending_replies.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int exp_v);
    if (errors < 40)
      $display("ERROR: reply %0d %s: got %0d, expected %0d", replies_seen, what, got, exp_v);
    errors++;
  endtask

  // divide by 2^sh, half away from zero
  function automatic longint shift_round(input longint v, input int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (v < 0)
      return -((-v + half) >>> sh);
    return (v + half) >>> sh;
  endfunction

  // divide by 2^17, toward zero
  function automatic int shift_trunc17(input longint p);
    if (p < 0)
      return -int'((-p) >>> 17);
    return int'(p >>> 17);
  endfunction

  function automatic void paint_pixel(input int row, input int col);
    if (row < 0 || row >= IMG || col < 0 || col >= IMG)
      return;
    frame_bits[row*IMG + col] = 1'b1;
    hit_row[hit_wr] = row;
    hit_col[hit_wr] = col;
    hit_wr = (hit_wr + 1) % HIT_SLOTS;
    if (hit_cnt < HIT_SLOTS)
      hit_cnt++;
  endfunction

  function automatic void paint_box(input int r, input int c, input int h, input int w);
    for (int i = 0; i < w; i++) begin
      paint_pixel(r, c + i);
      paint_pixel(r + h, c + i);
    end
    for (int i = 0; i < h; i++) begin
      paint_pixel(r + i, c);
      paint_pixel(r + i, c + w);
    end
  endfunction

  function automatic void paint_oval(input int r, input int c, input int a, input int b);
    longint cx;
    longint sy;
    longint nc;
    longint ns;
    longint c16;
    longint s16;
    cx = longint'(ONE_Q30);
    sy = 0;
    for (int k = 0; k < STEPS; k++) begin
      c16 = shift_round(cx, 14);
      s16 = shift_round(sy, 14);
      paint_pixel(r + shift_trunc17(longint'(a) * c16), c + shift_trunc17(longint'(b) * s16));
      nc = shift_round(cx * longint'(COS_STEP) - sy * longint'(SIN_STEP), 30);
      ns = shift_round(sy * longint'(COS_STEP) + cx * longint'(SIN_STEP), 30);
      cx = nc;
      sy = ns;
    end
  endfunction

  function automatic reply_t raster_outcome(input logic [1:0] kind, input int row,
                                            input int col, input int h, input int w);
    reply_t r;
    r.status = ST_REJECT;
    r.black = 1'b0;
    if (row <= IMG && col <= IMG) begin
      case (kind)
        REQ_RECT: begin
          paint_box(row, col, h, w);
          r.status = ST_DRAWN;
        end
        REQ_OVAL: begin
          paint_oval(row, col, h, w);
          r.status = ST_DRAWN;
        end
        REQ_READ: begin
          if (row >= 0 && row < IMG && col >= 0 && col < IMG) begin
            r.black = frame_bits[row*IMG + col];
            r.status = ST_READ;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic send_request(input logic [1:0] kind, input int row, input int col,
                              input int h, input int w, input bit typed,
                              input status_e st, input logic blk);
    reply_t r;
    start <= 1'b1;
    req_type_i <= kind;
    pos_row_i <= POS_W'(row);
    pos_col_i <= POS_W'(col);
    extent_rows_i <= EXT_W'(h);
    extent_cols_i <= EXT_W'(w);
    do @(posedge clk_i); while (busy !== 1'b0);
    r = raster_outcome(kind, row, col, h, w);
    if (typed) begin
      r.status = st;
      r.black = blk;
    end
    pending_replies.push_back(r);
    case (kind)
      REQ_RECT: n_rect++;
      REQ_OVAL: n_oval++;
      REQ_READ: n_read++;
      default: ;
    endcase
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_replies.size() != 0);
  endtask

  task automatic random_request(output logic [1:0] kind, output int row, output int col,
                                output int h, output int w);
    int pick;
    int slot;
    pick = $urandom_range(0, 99);
    if (pick < 30)
      kind = REQ_RECT;
    else if (pick < 45)
      kind = REQ_OVAL;
    else if (pick < 95)
      kind = REQ_READ;
    else
      kind = REQ_UNUSED;
    row = ($urandom_range(0, 99) < 85) ? int'($urandom_range(0, 300)) - 20
                                       : int'($urandom_range(0, 1023)) - 512;
    col = ($urandom_range(0, 99) < 85) ? int'($urandom_range(0, 300)) - 20
                                       : int'($urandom_range(0, 1023)) - 512;
    h = $urandom_range(0, 1023);
    w = $urandom_range(0, 1023);
    if (kind == REQ_RECT && $urandom_range(0, 99) >= 4) begin
      h = $urandom_range(0, 48);
      w = $urandom_range(0, 48);
    end
    if (kind == REQ_OVAL && $urandom_range(0, 99) < 70) begin
      h = $urandom_range(0, 400);
      w = $urandom_range(0, 400);
    end
    // aim most reads at or next to recently blackened pixels
    if (kind == REQ_READ && hit_cnt > 0 && $urandom_range(0, 99) < 60) begin
      slot = $urandom_range(0, hit_cnt - 1);
      row = hit_row[slot] + int'($urandom_range(0, 2)) - 1;
      col = hit_col[slot] + int'($urandom_range(0, 2)) - 1;
    end
  endtask

  task automatic add_row(input logic [1:0] kind, input int row, input int col, input int h,
                         input int w, input bit typed, input status_e st, input logic blk);
    plan_row_t p;
    p = '{kind, row, col, h, w, typed, st, blk};
    plan.push_back(p);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        report_mismatch("arrived with nothing pending, status", int'(cmd_status_o), -1);
      end else begin
        want = pending_replies.pop_front();
        if (cmd_status_o !== want.status)
          report_mismatch("cmd_status", int'(cmd_status_o), int'(want.status));
        if (pixel_black_o !== want.black)
          report_mismatch("pixel_black", int'(pixel_black_o), int'(want.black));
        if (want.status == ST_READ && want.black)
          n_black++;
        if (want.status == ST_REJECT)
          n_reject++;
      end
    end
  end

  initial begin
    logic [1:0] kind;
    int row;
    int col;
    int h;
    int w;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    //      kind        row   col   rows  cols  typed status     black
    add_row(REQ_READ,     0,    0,     0,    0, 1, ST_READ,   1'b0);
    add_row(REQ_READ,    -1,    5,     0,    0, 1, ST_REJECT, 1'b0);
    add_row(REQ_READ,   256,    0,     0,    0, 1, ST_REJECT, 1'b0);
    add_row(REQ_RECT,   257,    0,     4,    4, 1, ST_REJECT, 1'b0);
    add_row(REQ_OVAL,     0,  511,    20,   20, 1, ST_REJECT, 1'b0);
    add_row(REQ_UNUSED,   0,    0,     5,    5, 1, ST_REJECT, 1'b0);
    add_row(REQ_RECT,    10,   20,     5,    7, 1, ST_DRAWN,  1'b0);
    add_row(REQ_READ,    10,   20,     0,    0, 1, ST_READ,   1'b1);
    add_row(REQ_READ,    15,   26,     0,    0, 1, ST_READ,   1'b1);
    add_row(REQ_READ,    15,   27,     0,    0, 1, ST_READ,   1'b0);
    add_row(REQ_RECT,  -512, -512,  1023, 1023, 1, ST_DRAWN,  1'b0);
    add_row(REQ_RECT,   256,  256,     0,    0, 1, ST_DRAWN,  1'b0);
    add_row(REQ_RECT,     0,    0,     0,    0, 1, ST_DRAWN,  1'b0);
    add_row(REQ_READ,     0,    0,     0,    0, 1, ST_READ,   1'b0);
    add_row(REQ_OVAL,   128,  128,   200,  100, 1, ST_DRAWN,  1'b0);
    add_row(REQ_READ,   228,  128,     0,    0, 0, ST_DRAWN,  1'b0);
    add_row(REQ_READ,   128,  178,     0,    0, 0, ST_DRAWN,  1'b0);
    add_row(REQ_OVAL,     0,    0,  1023, 1023, 1, ST_DRAWN,  1'b0);
    add_row(REQ_OVAL,  -512, -512,  1023, 1023, 1, ST_DRAWN,  1'b0);
    add_row(REQ_OVAL,   256,  256,     0,    0, 1, ST_DRAWN,  1'b0);
    add_row(REQ_RECT,   250,  250,  1023,    0, 1, ST_DRAWN,  1'b0);
    add_row(REQ_READ,   255,  250,     0,    0, 0, ST_DRAWN,  1'b0);
    add_row(REQ_RECT,     5,    5,     0,    9, 1, ST_DRAWN,  1'b0);
    add_row(REQ_READ,     5,   13,     0,    0, 0, ST_DRAWN,  1'b0);
    add_row(REQ_READ,   511,  511,     0,    0, 1, ST_REJECT, 1'b0);
    add_row(REQ_READ,  -512, -512,     0,    0, 1, ST_REJECT, 1'b0);

    foreach (plan[i])
      send_request(plan[i].kind, plan[i].row, plan[i].col, plan[i].rows, plan[i].cols,
                   plan[i].typed, plan[i].status, plan[i].black);
    drain_replies();

    for (int phase = 0; phase < 3; phase++) begin
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        random_request(kind, row, col, h, w);
        send_request(kind, row, col, h, w, 1'b0, ST_DRAWN, 1'b0);
        if ($urandom_range(0, 99) < idle_pct[phase]) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 40)) @(posedge clk_i);
        end
      end
      drain_replies();
    end

    repeat (4200) @(posedge clk_i);

    $display("Covered %0d rectangles, %0d ellipses, %0d reads (%0d black), %0d rejects",
             n_rect, n_oval, n_read, n_black, n_reject);
    $display("Checked %0d replies over %0d cycles, %0d mismatches", replies_seen, cycles,
             errors);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/osr_pkg.sv
design/osr_rotator.sv
design/osr_datapath.sv
design/osr_ctrl.sv
design/outline_shape_rasterizer.sv
design/osr_check.sv
tb/sv/testbench.sv
